// ----- design/wsp_pkg.sv -----
// Wall segment projector package: register codes, reset values, config bundle
// and the sine table generator. Used by every module of the block but wsp_divider.
package wsp_pkg;

    localparam int COORD_WIDTH_DEF        = 32;
    localparam int SCREEN_COORD_WIDTH_DEF = 16;
    localparam int SINE_TABLE_DEPTH_DEF   = 256;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int TRIG_WIDTH      = 18;
    localparam int NEAR_WIDTH      = 31;
    localparam int AW_WIDTH        = 36;
    localparam int WN_WIDTH        = 62;
    localparam int DIM_WIDTH       = 12;

    localparam logic [31:0] CAM_POS_RESET  = 32'd0;
    localparam logic [15:0] CAM_ANGLE_RESET = 16'd0;
    localparam logic [30:0] NEAR_RESET     = 31'd65536;
    localparam logic [23:0] ASPECT_RESET   = 24'd87381;
    localparam logic [11:0] WIDTH_RESET    = 12'd320;
    localparam logic [11:0] HEIGHT_RESET   = 12'd240;
    localparam logic [30:0] WALL_RESET     = 31'd655360;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint Q30_ONE     = 64'sd1 << 30;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_CAM_POS_X     = 3'd0,
        REG_CAM_POS_Y     = 3'd1,
        REG_CAM_ANGLE     = 3'd2,
        REG_NEAR_PLANE    = 3'd3,
        REG_ASPECT_RATIO  = 3'd4,
        REG_SCREEN_WIDTH  = 3'd5,
        REG_SCREEN_HEIGHT = 3'd6,
        REG_WALL_HEIGHT   = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0]           cam_pos_x;
        logic signed [31:0]           cam_pos_y;
        logic [NEAR_WIDTH-1:0]        near;
        logic signed [TRIG_WIDTH-1:0] sin_v;
        logic signed [TRIG_WIDTH-1:0] cos_v;
        logic [AW_WIDTH-1:0]          aw;
        logic [WN_WIDTH-1:0]          wn;
        logic [DIM_WIDTH-1:0]         width;
        logic [DIM_WIDTH-1:0]         height;
    } wsp_cfg_t;

    // odd Taylor terms to x^11 in Q30, rounded to Q16
    function automatic logic [16:0] sine_q16(input longint x);
        longint x2;
        longint term;
        longint sum;
        longint q;
        x2   = (x * x) / Q30_ONE;
        term = x;
        sum  = x;
        term = (term * x2) / Q30_ONE;
        term = -term / 6;
        sum  = sum + term;
        term = (term * x2) / Q30_ONE;
        term = -term / 20;
        sum  = sum + term;
        term = (term * x2) / Q30_ONE;
        term = -term / 42;
        sum  = sum + term;
        term = (term * x2) / Q30_ONE;
        term = -term / 72;
        sum  = sum + term;
        term = (term * x2) / Q30_ONE;
        term = -term / 110;
        sum  = sum + term;
        if (sum < 0)
        begin
            sum = 0;
        end
        q = (sum + 8192) / 16384;
        if (q > 65536)
        begin
            q = 65536;
        end
        return q[16:0];
    endfunction

endpackage

// ----- design/wall_segment_projector.sv -----
// Wall segment projector top level: stream ports, config port, pipeline.
// The clip divider and the perspective dividers resolve one quotient bit per stage.
// Throughput: one word per cycle; a stall on m_tready holds the whole pipeline.
// Reset: rst_n asynchronous, clears valid bits and loads register defaults.
// Depends on wsp_pkg, wsp_config, wsp_transform, wsp_clip, wsp_project.
module wall_segment_projector
    import wsp_pkg::*;
#(
    parameter int COORD_WIDTH        = COORD_WIDTH_DEF,
    parameter int SCREEN_COORD_WIDTH = SCREEN_COORD_WIDTH_DEF,
    parameter int SINE_TABLE_DEPTH   = SINE_TABLE_DEPTH_DEF,
    localparam int IN_TW  = ((4 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_TW = ((6 * SCREEN_COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_addr,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // wall_a_x, wall_a_y, wall_b_x, wall_b_y
    input  logic [IN_TW-1:0]           s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // start_col, start_row_plus, start_row_minus, end_col, end_row_plus, end_row_minus
    output logic [OUT_TW-1:0]          m_tdata,
    // visible
    output logic [0:0]                 m_tuser
);

    localparam int CW  = COORD_WIDTH;
    localparam int SCW = SCREEN_COORD_WIDTH;
    localparam int PW  = (CW > 32) ? CW : 32;
    localparam int XW  = PW + 3;

    wsp_cfg_t cfg;
    logic     adv;

    logic                 t_valid, t_vis, t_nclip;
    logic signed [XW-1:0] t_sx, t_sy, t_ex, t_ey;
    logic                 c_valid, c_vis;
    logic signed [XW-1:0] c_sx, c_sy, c_ex, c_ey;
    logic                 p_valid, p_vis;
    logic [SCW-1:0]       scol, srp, srm, ecol, erp, erm;

    assign adv      = !p_valid || m_tready;
    assign s_tready = adv;

    wsp_config #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    wsp_transform #(
        .COORD_WIDTH (CW)
    ) u_transform (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s_tvalid),
        .wall_a_x  (signed'(s_tdata[CW-1:0])),
        .wall_a_y  (signed'(s_tdata[2*CW-1:CW])),
        .wall_b_x  (signed'(s_tdata[3*CW-1:2*CW])),
        .wall_b_y  (signed'(s_tdata[4*CW-1:3*CW])),
        .cfg       (cfg),
        .out_valid (t_valid),
        .sx        (t_sx),
        .sy        (t_sy),
        .ex        (t_ex),
        .ey        (t_ey),
        .vis       (t_vis),
        .nclip     (t_nclip)
    );

    wsp_clip #(
        .COORD_WIDTH (CW)
    ) u_clip (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (t_valid),
        .sx        (t_sx),
        .sy        (t_sy),
        .ex        (t_ex),
        .ey        (t_ey),
        .vis       (t_vis),
        .nclip     (t_nclip),
        .cfg       (cfg),
        .out_valid (c_valid),
        .sx_out    (c_sx),
        .sy_out    (c_sy),
        .ex_out    (c_ex),
        .ey_out    (c_ey),
        .vis_out   (c_vis)
    );

    wsp_project #(
        .COORD_WIDTH        (CW),
        .SCREEN_COORD_WIDTH (SCW)
    ) u_project (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (adv),
        .in_valid        (c_valid),
        .sx              (c_sx),
        .sy              (c_sy),
        .ex              (c_ex),
        .ey              (c_ey),
        .vis             (c_vis),
        .cfg             (cfg),
        .out_valid       (p_valid),
        .vis_out         (p_vis),
        .start_col       (scol),
        .start_row_plus  (srp),
        .start_row_minus (srm),
        .end_col         (ecol),
        .end_row_plus    (erp),
        .end_row_minus   (erm)
    );

    assign m_tvalid   = p_valid;
    assign m_tuser[0] = p_vis;
    assign m_tdata    = OUT_TW'({erm, erp, ecol, srm, srp, scol});

endmodule

// ----- design/wsp_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Needs num < den * 2**QW; carries a sideband word alongside. No dependencies.
module wsp_divider #(
    parameter int QW = 32,
    parameter int DW = 32,
    parameter int SW = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [QW+DW-1:0]   num,
    input  logic [DW-1:0]      den,
    input  logic [SW-1:0]      side_in,
    output logic               out_valid,
    output logic [QW-1:0]      quot,
    output logic [SW-1:0]      side_out
);

    localparam int NW = QW + DW;

    logic [NW-1:0] acc_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [SW-1:0] side_reg [QW];
    logic [QW-1:0] valid_reg;

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [NW-1:0] acc_in;
        logic [DW-1:0] den_in;
        logic [SW-1:0] side_k;
        logic          valid_in;
        logic [DW:0]   shifted;
        logic [DW+1:0] diff;
        logic          ge;
        logic [DW-1:0] rem;
        logic [NW-1:0] acc_next;

        if (k == 0)
        begin : g_first
            assign acc_in   = num;
            assign den_in   = den;
            assign side_k   = side_in;
            assign valid_in = in_valid;
        end
        else
        begin : g_rest
            assign acc_in   = acc_reg[k-1];
            assign den_in   = den_reg[k-1];
            assign side_k   = side_reg[k-1];
            assign valid_in = valid_reg[k-1];
        end

        assign shifted  = {acc_in[NW-1:QW], acc_in[QW-1]};
        assign diff     = {1'b0, shifted} - {2'b00, den_in};
        assign ge       = ~diff[DW+1];
        assign rem      = ge ? diff[DW-1:0] : shifted[DW-1:0];
        assign acc_next = {rem, acc_in[QW-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[k]  <= acc_next;
                den_reg[k]  <= den_in;
                side_reg[k] <= side_k;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quot      = acc_reg[QW-1][QW-1:0];
    assign side_out  = side_reg[QW-1];

endmodule

// ----- design/wsp_config.sv -----
// Configuration registers, sine/cosine lookup and derived products.
// Depends on wsp_pkg.
module wsp_config
    import wsp_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_addr,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,
    output wsp_cfg_t                   cfg
);

    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);

    logic [31:0] cam_pos_x_reg;
    logic [31:0] cam_pos_y_reg;
    logic [15:0] cam_angle_reg;
    logic [30:0] near_reg;
    logic [23:0] aspect_reg;
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [30:0] wall_reg;

    logic signed [TRIG_WIDTH-1:0] sin_reg;
    logic signed [TRIG_WIDTH-1:0] cos_reg;
    logic [AW_WIDTH-1:0]          aw_reg;
    logic [WN_WIDTH-1:0]          wn_reg;
    logic [NEAR_WIDTH-1:0]        near_eff;
    logic [15:0]                  cos_angle;

    logic [16:0] sine_rom [SINE_TABLE_DEPTH+1];

    for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++)
    begin : g_rom
        localparam longint XQ = (longint'(gi) * HALF_PI_Q30 +
                                 longint'(SINE_TABLE_DEPTH / 2)) /
                                longint'(SINE_TABLE_DEPTH);
        assign sine_rom[gi] = sine_q16(XQ);
    end

    function automatic logic signed [TRIG_WIDTH-1:0] trig_lookup(input logic [15:0] a);
        logic [13+IW:0] prod;
        logic [IW-1:0]  idx;
        logic [IW-1:0]  ridx;
        logic [16:0]    mag;
        prod = (14+IW)'(a[13:0]) * (14+IW)'(SINE_TABLE_DEPTH);
        idx  = prod[13+IW:14];
        ridx = a[14] ? IW'(SINE_TABLE_DEPTH) - idx : idx;
        mag  = sine_rom[ridx];
        return a[15] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_pos_x_reg <= CAM_POS_RESET;
            cam_pos_y_reg <= CAM_POS_RESET;
            cam_angle_reg <= CAM_ANGLE_RESET;
            near_reg      <= NEAR_RESET;
            aspect_reg    <= ASPECT_RESET;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            wall_reg      <= WALL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_CAM_POS_X:     cam_pos_x_reg <= cfg_wdata;
                REG_CAM_POS_Y:     cam_pos_y_reg <= cfg_wdata;
                REG_CAM_ANGLE:     cam_angle_reg <= cfg_wdata[15:0];
                REG_NEAR_PLANE:    near_reg      <= cfg_wdata[30:0];
                REG_ASPECT_RATIO:  aspect_reg    <= cfg_wdata[23:0];
                REG_SCREEN_WIDTH:  width_reg     <= cfg_wdata[11:0];
                REG_SCREEN_HEIGHT: height_reg    <= cfg_wdata[11:0];
                REG_WALL_HEIGHT:   wall_reg      <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    assign near_eff  = (near_reg == '0) ? NEAR_WIDTH'(1) : near_reg;
    assign cos_angle = cam_angle_reg + 16'h4000;

    // derived terms are registered and follow the registers in the next cycle
    always_ff @(posedge clk)
    begin
        sin_reg <= trig_lookup(cam_angle_reg);
        cos_reg <= trig_lookup(cos_angle);
        aw_reg  <= AW_WIDTH'(aspect_reg) * AW_WIDTH'(width_reg);
        wn_reg  <= WN_WIDTH'(wall_reg) * WN_WIDTH'(near_eff);
    end

    assign cfg.cam_pos_x = signed'(cam_pos_x_reg);
    assign cfg.cam_pos_y = signed'(cam_pos_y_reg);
    assign cfg.near      = near_eff;
    assign cfg.sin_v     = sin_reg;
    assign cfg.cos_v     = cos_reg;
    assign cfg.aw        = aw_reg;
    assign cfg.wn        = wn_reg;
    assign cfg.width     = width_reg;
    assign cfg.height    = height_reg;

endmodule

// ----- design/wsp_transform.sv -----
// Camera-space transform and near-plane classification, four stages.
// Depends on wsp_pkg.
module wsp_transform
    import wsp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int PW = (COORD_WIDTH > 32) ? COORD_WIDTH : 32,
    localparam int XW = PW + 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] wall_a_x,
    input  logic signed [COORD_WIDTH-1:0] wall_a_y,
    input  logic signed [COORD_WIDTH-1:0] wall_b_x,
    input  logic signed [COORD_WIDTH-1:0] wall_b_y,
    input  wsp_cfg_t                      cfg,
    output logic                          out_valid,
    output logic signed [XW-1:0]          sx,
    output logic signed [XW-1:0]          sy,
    output logic signed [XW-1:0]          ex,
    output logic signed [XW-1:0]          ey,
    output logic                          vis,
    output logic                          nclip
);

    localparam int DXW = PW + 1;
    localparam int PRW = DXW + TRIG_WIDTH;

    logic [3:0] valid_reg;

    logic signed [DXW-1:0] dax_reg, day_reg, dbx_reg, dby_reg;
    logic signed [PRW-1:0] cxa_reg, sya_reg, sxa_reg, cya_reg;
    logic signed [PRW-1:0] cxb_reg, syb_reg, sxb_reg, cyb_reg;
    logic signed [XW-1:0]  xa_reg, ya_reg, xb_reg, yb_reg;
    logic signed [XW-1:0]  sx_reg, sy_reg, ex_reg, ey_reg;
    logic                  vis_reg, nclip_reg;

    logic signed [PRW:0]  xa_sum, ya_sum, xb_sum, yb_sum;
    logic signed [XW-1:0] nz;
    logic                 behind_a, behind_b;

    assign xa_sum = (PRW+1)'(cxa_reg) - (PRW+1)'(sya_reg);
    assign ya_sum = (PRW+1)'(sxa_reg) + (PRW+1)'(cya_reg);
    assign xb_sum = (PRW+1)'(cxb_reg) - (PRW+1)'(syb_reg);
    assign yb_sum = (PRW+1)'(sxb_reg) + (PRW+1)'(cyb_reg);

    assign nz       = XW'(signed'({1'b0, cfg.near}));
    assign behind_a = ya_reg < nz;
    assign behind_b = yb_reg < nz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dax_reg <= DXW'(wall_a_x) - DXW'(cfg.cam_pos_x);
            day_reg <= DXW'(wall_a_y) - DXW'(cfg.cam_pos_y);
            dbx_reg <= DXW'(wall_b_x) - DXW'(cfg.cam_pos_x);
            dby_reg <= DXW'(wall_b_y) - DXW'(cfg.cam_pos_y);

            cxa_reg <= cfg.cos_v * dax_reg;
            sya_reg <= cfg.sin_v * day_reg;
            sxa_reg <= cfg.sin_v * dax_reg;
            cya_reg <= cfg.cos_v * day_reg;
            cxb_reg <= cfg.cos_v * dbx_reg;
            syb_reg <= cfg.sin_v * dby_reg;
            sxb_reg <= cfg.sin_v * dbx_reg;
            cyb_reg <= cfg.cos_v * dby_reg;

            // floor to Q16.16
            xa_reg <= xa_sum[PW+18:16];
            ya_reg <= ya_sum[PW+18:16];
            xb_reg <= xb_sum[PW+18:16];
            yb_reg <= yb_sum[PW+18:16];

            // start behind: swap endpoints
            sx_reg    <= behind_a ? xb_reg : xa_reg;
            sy_reg    <= behind_a ? yb_reg : ya_reg;
            ex_reg    <= behind_a ? xa_reg : xb_reg;
            ey_reg    <= behind_a ? ya_reg : yb_reg;
            vis_reg   <= !(behind_a && behind_b);
            nclip_reg <= behind_a ? behind_a : behind_b;
        end
    end

    assign out_valid = valid_reg[3];
    assign sx        = sx_reg;
    assign sy        = sy_reg;
    assign ex        = ex_reg;
    assign ey        = ey_reg;
    assign vis       = vis_reg;
    assign nclip     = nclip_reg;

endmodule

// ----- design/wsp_clip.sv -----
// Near-plane clip of the end point: operand stage, product stage,
// pipelined divider and update stage. Depends on wsp_pkg and wsp_divider.
module wsp_clip
    import wsp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int PW = (COORD_WIDTH > 32) ? COORD_WIDTH : 32,
    localparam int XW = PW + 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [XW-1:0] sx,
    input  logic signed [XW-1:0] sy,
    input  logic signed [XW-1:0] ex,
    input  logic signed [XW-1:0] ey,
    input  logic                 vis,
    input  logic                 nclip,
    input  wsp_cfg_t             cfg,
    output logic                 out_valid,
    output logic signed [XW-1:0] sx_out,
    output logic signed [XW-1:0] sy_out,
    output logic signed [XW-1:0] ex_out,
    output logic signed [XW-1:0] ey_out,
    output logic                 vis_out
);

    localparam int SW = 4 * XW + 3;

    logic signed [XW-1:0] nz;
    logic signed [XW:0]   d, num_w, den_w;
    logic [XW:0]          mag_w;

    logic [1:0]           valid_reg;
    logic [SW-1:0]        side0_reg, side1_reg;
    logic [XW-1:0]        mag_reg, cnum_reg, cden_reg, cden1_reg;
    logic [2*XW-1:0]      prod_reg;

    logic                 dv_valid;
    logic [XW-1:0]        q;
    logic [SW-1:0]        side_q;

    logic signed [XW-1:0] qsx, qsy, qex, qey;
    logic                 qvis, qclip, qneg;
    logic signed [XW:0]   ex_clip;

    logic                 valid_o_reg;
    logic signed [XW-1:0] sx_o_reg, sy_o_reg, ex_o_reg, ey_o_reg;
    logic                 vis_o_reg;

    assign nz    = XW'(signed'({1'b0, cfg.near}));
    assign d     = (XW+1)'(ex) - (XW+1)'(sx);
    assign mag_w = d[XW] ? -d : d;
    assign num_w = (XW+1)'(sy) - (XW+1)'(nz);
    assign den_w = (XW+1)'(sy) - (XW+1)'(ey);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side0_reg <= {sx, sy, ex, ey, vis, nclip, d[XW]};
            mag_reg   <= mag_w[XW-1:0];
            cnum_reg  <= num_w[XW-1:0];
            cden_reg  <= den_w[XW-1:0];
            side1_reg <= side0_reg;
            cden1_reg <= cden_reg;
            prod_reg  <= (2*XW)'(cnum_reg) * (2*XW)'(mag_reg);
        end
    end

    wsp_divider #(
        .QW (XW),
        .DW (XW),
        .SW (SW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (valid_reg[1]),
        .num       (prod_reg),
        .den       (cden1_reg),
        .side_in   (side1_reg),
        .out_valid (dv_valid),
        .quot      (q),
        .side_out  (side_q)
    );

    assign {qsx, qsy, qex, qey, qvis, qclip, qneg} = side_q;
    assign ex_clip = qneg ? (XW+1)'(qsx) - signed'((XW+1)'(q))
                          : (XW+1)'(qsx) + signed'((XW+1)'(q));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_o_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_o_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_o_reg  <= qsx;
            sy_o_reg  <= qsy;
            ex_o_reg  <= qclip ? ex_clip[XW-1:0] : qex;
            ey_o_reg  <= qclip ? nz : qey;
            vis_o_reg <= qvis;
        end
    end

    assign out_valid = valid_o_reg;
    assign sx_out    = sx_o_reg;
    assign sy_out    = sy_o_reg;
    assign ex_out    = ex_o_reg;
    assign ey_out    = ey_o_reg;
    assign vis_out   = vis_o_reg;

endmodule

// ----- design/wsp_project.sv -----
// Perspective divide, screen scaling and saturation for both endpoints;
// the last stage is the output register. Depends on wsp_pkg and wsp_divider.
module wsp_project
    import wsp_pkg::*;
#(
    parameter int COORD_WIDTH        = COORD_WIDTH_DEF,
    parameter int SCREEN_COORD_WIDTH = SCREEN_COORD_WIDTH_DEF,
    localparam int PW = (COORD_WIDTH > 32) ? COORD_WIDTH : 32,
    localparam int XW = PW + 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [XW-1:0]          sx,
    input  logic signed [XW-1:0]          sy,
    input  logic signed [XW-1:0]          ex,
    input  logic signed [XW-1:0]          ey,
    input  logic                          vis,
    input  wsp_cfg_t                      cfg,
    output logic                          out_valid,
    output logic                          vis_out,
    output logic [SCREEN_COORD_WIDTH-1:0] start_col,
    output logic [SCREEN_COORD_WIDTH-1:0] start_row_plus,
    output logic [SCREEN_COORD_WIDTH-1:0] start_row_minus,
    output logic [SCREEN_COORD_WIDTH-1:0] end_col,
    output logic [SCREEN_COORD_WIDTH-1:0] end_row_plus,
    output logic [SCREEN_COORD_WIDTH-1:0] end_row_minus
);

    localparam int SCW  = SCREEN_COORD_WIDTH;
    localparam int MW   = XW - 1;
    localparam int QP   = (MW > NEAR_WIDTH) ? MW : NEAR_WIDTH;
    localparam int NP   = QP + MW;
    localparam int PNW  = MW + NEAR_WIDTH;
    localparam int SUMW = QP + 5;

    logic [1:0]           valid_reg;
    logic [MW-1:0]        ms_reg, me_reg, zs_reg, ze_reg, zs1_reg, ze1_reg;
    logic                 sgs_reg, sge_reg, sgs1_reg, sge1_reg, vis0_reg, vis1_reg;
    logic [PNW-1:0]       pns_reg, pne_reg;
    logic signed [XW-1:0] asx, aex;

    logic                 v_t1s, v_rs, v_t1e, v_re;
    logic [QP-1:0]        t1s, rs, t1e, re;
    logic                 d_sgs, d_vis_a, d_sge, d_vis_b;

    logic                 valid2_reg;
    logic [QP+AW_WIDTH-1:0]        pas_reg, pae_reg;
    logic [QP+DIM_WIDTH-1:0]       pvs_reg, pve_reg;
    logic                 sgs2_reg, sge2_reg, vis2_reg;

    logic signed [SUMW-1:0] half_w, half_h, t2s, t2e, vs, ve;
    logic signed [SUMW-1:0] col_s, col_e, rps, rms, rpe, rme;

    logic                 valid_o_reg, vis_o_reg;
    logic [SCW-1:0]       scol_reg, srp_reg, srm_reg, ecol_reg, erp_reg, erm_reg;

    function automatic logic [SCW-1:0] sat(input logic signed [SUMW-1:0] v);
        logic signed [SUMW-1:0] hi;
        logic signed [SUMW-1:0] lo;
        hi = signed'({{(SUMW-SCW+1){1'b0}}, {(SCW-1){1'b1}}});
        lo = ~hi;
        if (v > hi)
        begin
            return hi[SCW-1:0];
        end
        else if (v < lo)
        begin
            return lo[SCW-1:0];
        end
        return v[SCW-1:0];
    endfunction

    assign asx = sx[XW-1] ? -sx : sx;
    assign aex = ex[XW-1] ? -ex : ex;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ms_reg   <= asx[MW-1:0];
            me_reg   <= aex[MW-1:0];
            zs_reg   <= sy[MW-1:0];
            ze_reg   <= ey[MW-1:0];
            sgs_reg  <= sx[XW-1];
            sge_reg  <= ex[XW-1];
            vis0_reg <= vis;

            pns_reg  <= PNW'(ms_reg) * PNW'(cfg.near);
            pne_reg  <= PNW'(me_reg) * PNW'(cfg.near);
            zs1_reg  <= zs_reg;
            ze1_reg  <= ze_reg;
            sgs1_reg <= sgs_reg;
            sge1_reg <= sge_reg;
            vis1_reg <= vis0_reg;
        end
    end

    wsp_divider #(.QW (QP), .DW (MW), .SW (1)) u_div_t1s (
        .clk (clk), .rst_n (rst_n), .en (en), .in_valid (valid_reg[1]),
        .num (NP'(pns_reg)), .den (zs1_reg), .side_in (sgs1_reg),
        .out_valid (v_t1s), .quot (t1s), .side_out (d_sgs)
    );

    wsp_divider #(.QW (QP), .DW (MW), .SW (1)) u_div_rs (
        .clk (clk), .rst_n (rst_n), .en (en), .in_valid (valid_reg[1]),
        .num (NP'(cfg.wn)), .den (zs1_reg), .side_in (vis1_reg),
        .out_valid (v_rs), .quot (rs), .side_out (d_vis_a)
    );

    wsp_divider #(.QW (QP), .DW (MW), .SW (1)) u_div_t1e (
        .clk (clk), .rst_n (rst_n), .en (en), .in_valid (valid_reg[1]),
        .num (NP'(pne_reg)), .den (ze1_reg), .side_in (sge1_reg),
        .out_valid (v_t1e), .quot (t1e), .side_out (d_sge)
    );

    wsp_divider #(.QW (QP), .DW (MW), .SW (1)) u_div_re (
        .clk (clk), .rst_n (rst_n), .en (en), .in_valid (valid_reg[1]),
        .num (NP'(cfg.wn)), .den (ze1_reg), .side_in (vis1_reg),
        .out_valid (v_re), .quot (re), .side_out (d_vis_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid2_reg  <= 1'b0;
            valid_o_reg <= 1'b0;
        end
        else if (en)
        begin
            valid2_reg  <= v_t1s & v_rs & v_t1e & v_re;
            valid_o_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pas_reg  <= (QP+AW_WIDTH)'(t1s) * (QP+AW_WIDTH)'(cfg.aw);
            pae_reg  <= (QP+AW_WIDTH)'(t1e) * (QP+AW_WIDTH)'(cfg.aw);
            pvs_reg  <= (QP+DIM_WIDTH)'(rs) * (QP+DIM_WIDTH)'(cfg.height);
            pve_reg  <= (QP+DIM_WIDTH)'(re) * (QP+DIM_WIDTH)'(cfg.height);
            sgs2_reg <= d_sgs;
            sge2_reg <= d_sge;
            vis2_reg <= d_vis_a & d_vis_b;
        end
    end

    assign half_w = signed'(SUMW'(cfg.width[DIM_WIDTH-1:1]));
    assign half_h = signed'(SUMW'(cfg.height[DIM_WIDTH-1:1]));
    assign t2s    = signed'(SUMW'(pas_reg[QP+AW_WIDTH-1:33]));
    assign t2e    = signed'(SUMW'(pae_reg[QP+AW_WIDTH-1:33]));
    assign vs     = signed'(SUMW'(pvs_reg[QP+DIM_WIDTH-1:17]));
    assign ve     = signed'(SUMW'(pve_reg[QP+DIM_WIDTH-1:17]));

    assign col_s = (sgs2_reg ? -t2s : t2s) + half_w;
    assign col_e = (sge2_reg ? -t2e : t2e) + half_w;
    assign rps   = half_h + vs;
    assign rms   = half_h - vs;
    assign rpe   = half_h + ve;
    assign rme   = half_h - ve;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vis_o_reg <= vis2_reg;
            scol_reg  <= vis2_reg ? sat(col_s) : '0;
            srp_reg   <= vis2_reg ? sat(rps) : '0;
            srm_reg   <= vis2_reg ? sat(rms) : '0;
            ecol_reg  <= vis2_reg ? sat(col_e) : '0;
            erp_reg   <= vis2_reg ? sat(rpe) : '0;
            erm_reg   <= vis2_reg ? sat(rme) : '0;
        end
    end

    assign out_valid       = valid_o_reg;
    assign vis_out         = vis_o_reg;
    assign start_col       = scol_reg;
    assign start_row_plus  = srp_reg;
    assign start_row_minus = srm_reg;
    assign end_col         = ecol_reg;
    assign end_row_plus    = erp_reg;
    assign end_row_minus   = erm_reg;

endmodule
